// ===== rtl/scrr_pkg.sv =====
// Shared types and constants for the SPI counter readout retry unit.
`default_nettype none

package scrr_pkg;

   localparam int SEND_BITS     = 32;
   localparam int COUNT_BITS    = 31;
   localparam int ATTEMPT_BITS  = 7;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 48;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 7;

   // opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_BIT   = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ECHO_MODE   = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RETRY_LIMIT = 1'b1;

   typedef struct packed {
      logic                    echo_mode;
      logic [ATTEMPT_BITS-1:0] retry_limit;
   } cfg_type;

   typedef struct packed {
      logic                    status;
      logic                    zero_read_error;
      logic [ATTEMPT_BITS-1:0] attempts_used;
      logic                    desync_flag;
      logic [COUNT_BITS-1:0]   count_value;
      logic                    done_res;
      logic                    mosi_level;
      logic                    chip_select;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/spi_counter_readout_retry_unit.sv =====
// Top level of the SPI counter readout retry unit: channels, config and result register.
`default_nettype none

// SPI master (mode 0, MSB first) that reads a counter one bit period per item.
// Request channel (req_): tuser is the opcode; a start item carries the send
// word and raises chip select, a bit item carries the MISO level sampled in
// that period. Result channel (rsp_): one item per request, giving chip
// select, the MOSI level for the next period and, once all bits of an attempt
// are in, the count, desync flag and zero-read error. A zero count starts a
// new attempt on its own until the retry limit is reached.
// Latency: the result is registered; it is shown the cycle after the request
// is taken. Throughput: one item per cycle while results are taken, set by the
// single state update of the shift registers and counters in scrr_core.
// Stall: while a result waits and rsp_tready is low, req_tready is low; as
// soon as the result is taken a new item can enter in the same cycle.
// Reset (synchronous): idle, MOSI low, no attempts, no result pending,
// echo_mode 0 and retry_limit 1.
// csr_: write-only, taken whenever csr_we is high; write while idle only.

module spi_counter_readout_retry_unit #(
   parameter int WORD_BITS = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // lowest bit up: send_word[31:0], miso_bit[32], zero pad
   input  wire  [scrr_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // opcode
   input  wire                                 req_tuser,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // lowest bit up: chip_select[0], mosi_level[1], done_res[2],
   // count_value[33:3], desync_flag[34], attempts_used[41:35],
   // zero_read_error[42], zero pad
   output logic [scrr_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // status
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   input  wire                                 csr_we,
   input  wire  [scrr_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire  [scrr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import scrr_pkg::*;

   cfg_type cfg_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    valid_ff;
   logic    item_take;

   // output register frees up in the cycle it is taken
   assign req_tready = !valid_ff || rsp_tready;
   assign item_take  = req_tvalid && req_tready;

   scrr_core #(
      .WORD_BITS (WORD_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .item_take (item_take),
      .opcode    (req_tuser),
      .send_word (req_tdata[SEND_BITS-1:0]),
      .miso_bit  (req_tdata[SEND_BITS]),
      .cfg       (cfg_ff),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.echo_mode   <= 1'b0;
         cfg_ff.retry_limit <= ATTEMPT_BITS'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ECHO_MODE:   cfg_ff.echo_mode   <= csr_wdata[0];
            CSR_RETRY_LIMIT: cfg_ff.retry_limit <= csr_wdata[ATTEMPT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (item_take) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {(RSP_DATA_BITS - $bits(rsp_type) + 1)'(0),
                        rsp_ff.zero_read_error, rsp_ff.attempts_used,
                        rsp_ff.desync_flag, rsp_ff.count_value, rsp_ff.done_res,
                        rsp_ff.mosi_level, rsp_ff.chip_select};

`ifndef SYNTHESIS
   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      item_take |=> rsp_tvalid)
      else $error("item taken without a result following");
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while result stalled");
   a_done_releases_cs: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.done_res) |-> (!rsp_ff.chip_select && !rsp_ff.status))
      else $error("finished readout with chip select still held");
   a_zero_error_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.zero_read_error) |-> (rsp_ff.done_res &&
      (rsp_ff.count_value == '0)))
      else $error("zero-read error on a non-zero or unfinished count");
`endif

endmodule

`default_nettype wire

// ===== rtl/scrr_core.sv =====
// Transfer state, shift registers and retry control of the SPI readout.
`default_nettype none

module scrr_core #(
   parameter int WORD_BITS = 32
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             item_take,
   input  wire                             opcode,
   input  wire  [scrr_pkg::SEND_BITS-1:0]  send_word,
   input  wire                             miso_bit,
   input  wire  scrr_pkg::cfg_type         cfg,
   output scrr_pkg::rsp_type               rsp
);
   import scrr_pkg::*;

   localparam int POS_BITS = $clog2(WORD_BITS + 1);
   localparam int IDX_BITS = $clog2(WORD_BITS);
   localparam int EXT_BITS = (WORD_BITS > 32) ? WORD_BITS : 32;

   logic [POS_BITS-1:0]     pos_ff, pos_in;
   logic [WORD_BITS-1:0]    rx_ff, rx_in;
   logic [WORD_BITS-1:0]    tx_ff, tx_in;
   logic                    active_ff, active_in;
   logic [ATTEMPT_BITS-1:0] attempts_ff, attempts_in;
   logic                    line_ff, line_in;

   logic [WORD_BITS-1:0]    rx_next;
   logic [POS_BITS-1:0]     pos_next;
   logic [IDX_BITS-1:0]     tx_idx;
   logic [EXT_BITS-1:0]     rx_ext;
   logic [ATTEMPT_BITS-1:0] limit_eff;
   logic                    count_zero;

   assign rx_next    = {rx_ff[WORD_BITS-2:0], miso_bit};
   assign pos_next   = pos_ff + POS_BITS'(1);
   assign tx_idx     = IDX_BITS'(WORD_BITS - 1) - pos_next[IDX_BITS-1:0];
   assign rx_ext     = EXT_BITS'(rx_next);
   assign count_zero = (rx_next[WORD_BITS-1:1] == '0);
   // a limit of zero behaves as one
   assign limit_eff  = (cfg.retry_limit == '0) ? ATTEMPT_BITS'(1) : cfg.retry_limit;

   always_comb begin
      pos_in      = pos_ff;
      rx_in       = rx_ff;
      tx_in       = tx_ff;
      active_in   = active_ff;
      attempts_in = attempts_ff;
      line_in     = line_ff;
      rsp         = '0;

      unique case (opcode)
         OP_START: begin
            tx_in       = WORD_BITS'(send_word);
            attempts_in = ATTEMPT_BITS'(1);
            pos_in      = '0;
            rx_in       = '0;
            active_in   = 1'b1;
            line_in     = 1'b0;
            rsp.chip_select   = 1'b1;
            rsp.attempts_used = attempts_in;
         end
         OP_BIT: begin
            if (!active_ff) begin
               rsp.status        = 1'b1;
               rsp.mosi_level    = line_ff;
               rsp.attempts_used = attempts_ff;
            end else if (pos_next < POS_BITS'(WORD_BITS)) begin
               rx_in   = rx_next;
               pos_in  = pos_next;
               line_in = cfg.echo_mode ? miso_bit : tx_ff[tx_idx];
               rsp.chip_select   = 1'b1;
               rsp.mosi_level    = line_in;
               rsp.attempts_used = attempts_ff;
            end else if (count_zero && (attempts_ff < limit_eff)) begin
               // zero count, attempts left: go again straight away
               attempts_in = attempts_ff + ATTEMPT_BITS'(1);
               pos_in      = '0;
               rx_in       = '0;
               active_in   = 1'b1;
               line_in     = 1'b0;
               rsp.chip_select   = 1'b1;
               rsp.attempts_used = attempts_in;
            end else begin
               rx_in     = rx_next;
               active_in = 1'b0;
               pos_in    = '0;
               line_in   = 1'b0;
               rsp.done_res        = 1'b1;
               rsp.count_value     = rx_ext[COUNT_BITS:1];
               rsp.desync_flag     = rx_next[0];
               rsp.zero_read_error = count_zero;
               rsp.attempts_used   = attempts_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         active_ff   <= 1'b0;
         attempts_ff <= '0;
         line_ff     <= 1'b0;
      end else if (item_take) begin
         pos_ff      <= pos_in;
         active_ff   <= active_in;
         attempts_ff <= attempts_in;
         line_ff     <= line_in;
      end
   end

   // shift registers: always written by start before use
   always_ff @(posedge clock) begin
      if (item_take) begin
         rx_ff <= rx_in;
         tx_ff <= tx_in;
      end
   end

`ifndef SYNTHESIS
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < POS_BITS'(WORD_BITS))
      else $error("bit position reached word length while held");
   a_idle_pos_zero: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (pos_ff == '0) && !line_ff)
      else $error("idle with stale bit position or MOSI level");
   a_active_attempts: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (attempts_ff != '0))
      else $error("transfer active with no attempt counted");
`endif

endmodule

`default_nettype wire

// ===== tb/spi_counter_readout_retry_unit_test.sv =====
// Self-checking testbench for the SPI counter readout retry unit.
`timescale 1ns / 100ps

module spi_counter_readout_retry_unit_test;
   import scrr_pkg::*;

   // generous cap on the length of the slowest legal run
   localparam int CYCLE_LIMIT = 500000;
   localparam int SHOWN_MAX   = 10;

   // one request item as the driver sees it
   typedef struct packed {
      logic                 opcode;
      logic [SEND_BITS-1:0] send_word;
      logic                 miso_bit;
   } spi_req_type;

   logic clock      = 1'b0;
   logic reset      = 1'b1;
   logic req_tvalid = 1'b0;
   logic rsp_tready = 1'b0;
   logic csr_we     = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   spi_req_type req_cur = '0;

   wire                     req_tready;
   wire [REQ_DATA_BITS-1:0] req_tdata;
   wire                     req_tuser;
   wire [RSP_DATA_BITS-1:0] rsp_tdata;
   wire                     rsp_tuser;
   wire                     rsp_tvalid;

   // lowest bit up: send_word, miso_bit, zero pad
   assign req_tdata = {{(REQ_DATA_BITS - SEND_BITS - 1){1'b0}}, req_cur.miso_bit,
                       req_cur.send_word};
   assign req_tuser = req_cur.opcode;

   spi_counter_readout_retry_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow of the block: register copies and transfer state
   // ---------------------------------------------------------------------
   logic                    echo_sel   = 1'b0;
   logic [ATTEMPT_BITS-1:0] retry_max  = 7'd1;
   logic [5:0]              rd_bitpos  = '0;
   logic [SEND_BITS-1:0]    rd_rx      = '0;
   logic [SEND_BITS-1:0]    rd_tx      = '0;
   logic                    rd_active  = 1'b0;
   logic [ATTEMPT_BITS-1:0] rd_attempts = '0;
   logic                    rd_mosi    = 1'b0;

   spi_req_type item_q[$];   // items waiting for the driver
   rsp_type  readout_q[$];   // predicted results, oldest first

   logic req_fire = 1'b0;    // request item taken at the last rising edge
   logic steady   = 1'b0;    // no idling on either side while set

   int fail_count  = 0;
   int items_taken = 0;
   int done_seen   = 0;
   int zerr_seen   = 0;
   int retry_seen  = 0;
   int cycle_count = 0;

   // Advance the shadow by one accepted item and return the result it causes.
   function automatic rsp_type readout_step(input spi_req_type it);
      rsp_type r;
      logic [ATTEMPT_BITS-1:0] lim;
      logic [COUNT_BITS-1:0]   cnt;
      r = '0;
      if (it.opcode == OP_START) begin
         // start, also while a transfer runs: new readout at attempt one
         rd_tx       = it.send_word;
         rd_attempts = 7'd1;
         rd_bitpos   = '0;
         rd_rx       = '0;
         rd_active   = 1'b1;
         rd_mosi     = 1'b0;
         r.chip_select = 1'b1;
      end else if (!rd_active) begin
         // bit while idle: ignored, nothing moves
         r.status = 1'b1;
      end else begin
         rd_rx     = {rd_rx[SEND_BITS-2:0], it.miso_bit};
         rd_bitpos = rd_bitpos + 6'd1;
         if (rd_bitpos < SEND_BITS) begin
            rd_mosi = echo_sel ? it.miso_bit : rd_tx[SEND_BITS - 1 - rd_bitpos];
            r.chip_select = 1'b1;
         end else begin
            cnt = rd_rx[SEND_BITS-1:1];
            lim = (retry_max == '0) ? 7'd1 : retry_max;   // zero limit acts as one
            if (cnt == '0 && rd_attempts < lim) begin
               // automatic retry, chip select stays asserted
               rd_attempts = rd_attempts + 7'd1;
               rd_bitpos   = '0;
               rd_rx       = '0;
               rd_mosi     = 1'b0;
               r.chip_select = 1'b1;
            end else begin
               rd_active = 1'b0;
               rd_bitpos = '0;
               rd_mosi   = 1'b0;
               r.done_res        = 1'b1;
               r.count_value     = cnt;
               r.desync_flag     = rd_rx[0];
               r.zero_read_error = (cnt == '0);
            end
         end
      end
      r.mosi_level    = rd_mosi;
      r.attempts_used = rd_attempts;
      return r;
   endfunction

   function automatic string rsp_text(input rsp_type r);
      return $sformatf("cs=%0d mosi=%0d done=%0d count=%h desync=%0d att=%0d zerr=%0d st=%0d",
                       r.chip_select, r.mosi_level, r.done_res, r.count_value,
                       r.desync_flag, r.attempts_used, r.zero_read_error, r.status);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: inputs move on the falling edge only
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 28);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (item_q.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
            req_cur    <= item_q.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: both channels sampled on the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         // results first, so a result never meets the prediction of its own edge
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[COUNT_BITS+ATTEMPT_BITS+4:0]};
            if (got.done_res) begin
               done_seen++;
               if (got.zero_read_error) zerr_seen++;
               if (got.attempts_used > 7'd1) retry_seen++;
            end
            if (readout_q.size() == 0) begin
               fail_count++;
               if (fail_count <= SHOWN_MAX)
                  $display("unexpected result item: %s", rsp_text(got));
            end else begin
               want = readout_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= SHOWN_MAX)
                     $display("mismatch after %0d items\n  exp %s\n  got %s",
                              items_taken, rsp_text(want), rsp_text(got));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            readout_q.push_back(readout_step(req_cur));
            items_taken++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, readout_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // unused fields of an item get random content
   task automatic push_item(input logic op, input logic [SEND_BITS-1:0] word,
                            input logic miso);
      spi_req_type it;
      it.opcode    = op;
      it.send_word = (op == OP_START) ? word : $urandom;
      it.miso_bit  = (op == OP_BIT) ? miso : 1'($urandom_range(1));
      item_q.push_back(it);
   endtask

   // sender stops until the block has answered everything, then a short tail
   task automatic wait_idle();
      while (item_q.size() != 0 || req_tvalid || readout_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_ECHO_MODE) echo_sel = data[0];
      else                      retry_max = data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // One readout: a start, then whole attempts until the planned count is
   // non-zero or the limit is used up. Some are cut short in attempt one.
   task automatic push_readout(input int lim_eff, input int zero_pct, inout int added);
      logic [SEND_BITS-1:0] word;
      logic [SEND_BITS-1:0] rx;
      int   a;
      int   i;
      int   cut;
      logic more;
      case ($urandom_range(5))
         0:       word = 32'h0000_0000;
         1:       word = 32'hFFFF_FFFF;
         2:       word = 32'h8000_0000;
         3:       word = 32'h7FFF_FFFF;
         default: word = $urandom;
      endcase
      push_item(OP_START, word, 1'b0);
      added++;
      cut  = ($urandom_range(9) == 0) ? $urandom_range(1, 31) : 0;
      a    = 1;
      more = 1'b1;
      while (more) begin
         if ($urandom_range(99) < zero_pct) begin
            rx = {31'b0, 1'($urandom_range(1))};   // zero count, desync either way
         end else begin
            case ($urandom_range(3))
               0:       rx = 32'hFFFF_FFFF;
               1:       rx = 32'h0000_0002;
               default: rx = $urandom;
            endcase
         end
         for (i = SEND_BITS - 1; i >= 0; i--) begin
            push_item(OP_BIT, '0, rx[i]);
            added++;
            if (cut != 0 && a == 1 && SEND_BITS - i == cut) return;
         end
         more = (rx[SEND_BITS-1:1] == '0) && (a < lim_eff);
         a++;
      end
   endtask

   // One register setting and its share of random traffic.
   task automatic run_phase(input logic echo, input logic [ATTEMPT_BITS-1:0] lim,
                            input int zero_pct, input int budget);
      int added;
      int pause_at;
      int n;
      logic paused;
      wait_idle();
      // upper write bits of the echo register are don't-care
      csr_write(CSR_ECHO_MODE, {6'($urandom_range(63)), echo});
      csr_write(CSR_RETRY_LIMIT, lim);
      added    = 0;
      paused   = 1'b0;
      pause_at = $urandom_range(budget / 4, 3 * budget / 4);
      while (added < budget) begin
         if ($urandom_range(99) < 8) begin
            // stray bit items, mostly landing while idle
            for (n = $urandom_range(1, 3); n > 0; n--)
               push_item(OP_BIT, '0, 1'($urandom_range(1)));
         end else begin
            push_readout((lim == '0) ? 1 : int'(lim), zero_pct, added);
         end
         if (!paused && added >= pause_at) begin
            wait_idle();
            paused = 1'b1;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, under the reset settings
      push_item(OP_BIT, '0, 1'b0);                // bit while idle
      push_item(OP_BIT, '1, 1'b1);
      push_item(OP_START, 32'h0000_0000, 1'b1);   // first period low
      push_item(OP_BIT, '0, 1'b1);
      push_item(OP_BIT, '1, 1'b0);
      push_item(OP_START, 32'hFFFF_FFFF, 1'b0);   // start while active
      push_item(OP_BIT, '0, 1'b1);
      push_item(OP_BIT, '0, 1'b0);
      push_item(OP_BIT, '0, 1'b1);
      push_item(OP_BIT, '0, 1'b1);
      push_item(OP_START, 32'h8000_0000, 1'b1);   // send word MSB never driven
      push_item(OP_BIT, '0, 1'b0);
      push_item(OP_BIT, '0, 1'b1);
      push_item(OP_START, 32'h7FFF_FFFF, 1'b0);
      push_item(OP_BIT, '1, 1'b1);
      push_item(OP_BIT, '1, 1'b1);
      push_item(OP_BIT, '0, 1'b0);

      // random phases; the second runs with both sides always ready
      run_phase(1'b0, 7'd1, 30, 125);
      steady = 1'b1;
      run_phase(1'b1, 7'd0, 40, 125);             // zero limit behaves as one
      steady = 1'b0;
      run_phase(1'b0, 7'd127, 25, 125);
      run_phase(1'b1, 7'd2, 50, 125);
      run_phase(1'b0, 7'($urandom_range(3, 8)), 50, 125);
      run_phase(1'b1, 7'd1, 20, 125);

      wait_idle();
      $display("%0d request items taken over six register settings", items_taken);
      $display("%0d readouts finished: %0d after retries, %0d zero-read errors",
               done_seen, retry_seen, zerr_seen);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d failures", fail_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
